### hdl/cbs_pkg.sv
// Shared types, character codes and counter helpers for the chunk balance scanner.
// No dependencies; used by every module of the block.
package cbs_pkg;

  // Counter width of the open-bracket counts and width of the count outputs
  localparam int unsigned CountWidth = 16;
  localparam int unsigned OutWidth   = 16;

  typedef logic [CountWidth-1:0] count_t;

  localparam count_t CountMax = {CountWidth{1'b1}};

  // Character codes
  localparam logic [7:0] CharHash      = 8'h23;  // '#'
  localparam logic [7:0] CharStar      = 8'h2A;  // '*'
  localparam logic [7:0] CharSlash     = 8'h2F;  // '/'
  localparam logic [7:0] CharBackslash = 8'h5C;  // '\'
  localparam logic [7:0] CharSquote    = 8'h27;  // single quote
  localparam logic [7:0] CharDquote    = 8'h22;  // double quote
  localparam logic [7:0] CharLparen    = 8'h28;  // '('
  localparam logic [7:0] CharRparen    = 8'h29;  // ')'
  localparam logic [7:0] CharLbracket  = 8'h5B;  // '['
  localparam logic [7:0] CharRbracket  = 8'h5D;  // ']'
  localparam logic [7:0] CharLbrace    = 8'h7B;  // '{'
  localparam logic [7:0] CharRbrace    = 8'h7D;  // '}'

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  // Scanner state carried from byte to byte
  typedef struct packed {
    count_t paren;
    count_t bracket;
    count_t brace;
    quote_e quote;
    logic   escape;
    logic   block_cmt;
    logic   line_cmt;
    logic   slash;
    logic   star;
  } scan_state_t;

  // One line-end report
  typedef struct packed {
    logic                complete;
    logic [OutWidth-1:0] parens;
    logic [OutWidth-1:0] brackets;
    logic [OutWidth-1:0] braces;
    logic [1:0]          quote;
    logic                comment;
  } result_t;

  // Saturating increment
  function automatic count_t count_inc(count_t c);
    return (c == CountMax) ? c : count_t'(c + 1'b1);
  endfunction

  // Decrement that stops at zero
  function automatic count_t count_dec(count_t c);
    return (c == '0) ? c : count_t'(c - 1'b1);
  endfunction

endpackage

### hdl/cbs_scanner.sv
// Per-byte scan logic and scanner state register of the chunk balance scanner.
// Depends on cbs_pkg for state/result types, character codes and count helpers.
module cbs_scanner (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      text_byte_i,
  input  logic            line_last_i,
  input  logic            clear_first_i,
  output cbs_pkg::result_t res_o
);
  import cbs_pkg::*;

  scan_state_t state_q, state_d;
  scan_state_t cur;
  scan_state_t scn;
  logic        consumed;
  logic        done;
  logic [7:0]  closer;

  // Next-state function for one byte
  always_comb begin
    cur      = clear_first_i ? '0 : state_q;
    scn      = cur;
    consumed = 1'b0;
    closer   = (cur.quote == QUOTE_SINGLE) ? CharSquote : CharDquote;

    if (cur.line_cmt) begin
      // rest of line is ignored
    end else if (cur.block_cmt) begin
      if (cur.star && text_byte_i == CharSlash) begin
        scn.block_cmt = 1'b0;
        scn.star      = 1'b0;
      end else begin
        scn.star = (text_byte_i == CharStar);
      end
    end else if (cur.quote != QUOTE_NONE) begin
      if (cur.escape) begin
        scn.escape = 1'b0;
      end else if (text_byte_i == CharBackslash) begin
        scn.escape = 1'b1;
      end else if (text_byte_i == closer) begin
        scn.quote = QUOTE_NONE;
      end
    end else begin
      // a pending slash either opens a comment or is dropped
      if (cur.slash) begin
        scn.slash = 1'b0;
        if (text_byte_i == CharSlash) begin
          scn.line_cmt = 1'b1;
          consumed     = 1'b1;
        end else if (text_byte_i == CharStar) begin
          scn.block_cmt = 1'b1;
          scn.star      = 1'b0;
          consumed      = 1'b1;
        end
      end
      if (!consumed) begin
        case (text_byte_i)
          CharHash:     scn.line_cmt = 1'b1;
          CharSlash:    scn.slash    = 1'b1;
          CharSquote:   scn.quote    = QUOTE_SINGLE;
          CharDquote:   scn.quote    = QUOTE_DOUBLE;
          CharLparen:   scn.paren    = count_inc(cur.paren);
          CharRparen:   scn.paren    = count_dec(cur.paren);
          CharLbracket: scn.bracket  = count_inc(cur.bracket);
          CharRbracket: scn.bracket  = count_dec(cur.bracket);
          CharLbrace:   scn.brace    = count_inc(cur.brace);
          CharRbrace:   scn.brace    = count_dec(cur.brace);
          default:      ;
        endcase
      end
    end

    done = (scn.paren == '0) && (scn.bracket == '0) && (scn.brace == '0) &&
           (scn.quote == QUOTE_NONE) && !scn.block_cmt;

    // Line-end report, taken before the line-end clear
    res_o.complete = done;
    res_o.parens   = OutWidth'(scn.paren);
    res_o.brackets = OutWidth'(scn.bracket);
    res_o.braces   = OutWidth'(scn.brace);
    res_o.quote    = 2'(scn.quote);
    res_o.comment  = scn.block_cmt;

    // Line end drops per-line flags; a complete chunk starts over
    state_d = scn;
    if (line_last_i) begin
      state_d.slash    = 1'b0;
      state_d.star     = 1'b0;
      state_d.line_cmt = 1'b0;
      if (done) begin
        state_d = '0;
      end
    end
  end

  // State register, updated on each byte transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take_i) begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/cbs_result_reg.sv
// Output register of the chunk balance scanner: holds one line-end report.
// Depends on cbs_pkg for the result type.
module cbs_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cbs_pkg::result_t res_i,
  output logic             slot_free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbs_pkg::result_t res_o
);
  import cbs_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot is free when empty or being drained this cycle
  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hdl/code_chunk_balance_scanner.sv
// Chunk balance scanner top level: input handshake, scanner and result register.
// Depends on cbs_pkg, cbs_scanner and cbs_result_reg.
//
// Usage: source text enters one byte per transfer on the in_ channel, with
// line_last_i marking a line's final byte and clear_first_i wiping all scan
// state before its byte. Brackets are counted outside quotes and comments.
// Each transfer whose line_last_i is set yields one report on the out_
// channel; other bytes yield nothing.
// Timing: the report is registered and valid in the cycle after the transfer of
// the line's last byte. Throughput: one byte per cycle while in_ready_o is high;
// the per-byte update is a single level of flag checks plus one saturating counter step.
// Reset: all counts, quote and comment state clear, and no report is held.
// Stall: a report waits in the output register; in_ready_o drops only while
// that report is held and out_ready_i is low, and the scan state holds.
// Once a report shows a complete chunk, the scanner has already started over.
module code_chunk_balance_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        line_last_i,
  input  logic        clear_first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        chunk_complete_o,
  output logic [15:0] open_parens_o,
  output logic [15:0] open_brackets_o,
  output logic [15:0] open_braces_o,
  output logic [1:0]  quote_open_o,
  output logic        comment_open_o
);
  import cbs_pkg::*;

  logic    take;
  logic    slot_free;
  result_t scan_res;
  result_t out_res;

  assign in_ready_o = slot_free;
  assign take       = in_valid_i && in_ready_o;

  // Per-byte scanner with its state
  cbs_scanner u_scanner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .text_byte_i   (text_byte_i),
    .line_last_i   (line_last_i),
    .clear_first_i (clear_first_i),
    .res_o         (scan_res)
  );

  // Report register
  cbs_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && line_last_i),
    .res_i       (scan_res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign chunk_complete_o = out_res.complete;
  assign open_parens_o    = out_res.parens;
  assign open_brackets_o  = out_res.brackets;
  assign open_braces_o    = out_res.braces;
  assign quote_open_o     = out_res.quote;
  assign comment_open_o   = out_res.comment;

`ifndef ASSERT_OFF
  // A line-end transfer always produces a report next cycle
  a_line_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && line_last_i) |=> out_valid_o)
    else $error("line-end transfer produced no report");

  // A complete chunk reports nothing open
  a_complete_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_complete_o) |->
      (open_parens_o == '0 && open_brackets_o == '0 && open_braces_o == '0 &&
       quote_open_o == '0 && !comment_open_o))
    else $error("complete chunk reported with open state");

  // A stalled report blocks new input
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while report stalled");
`endif

endmodule
